[hw/rtl/best_rational_approximation_top_defines.svh]
// assertion macros used by the checker file
`ifndef BEST_RATIONAL_APPROXIMATION_TOP_DEFINES_SVH
`define BEST_RATIONAL_APPROXIMATION_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BRA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bra_pkg.sv]
// shared types and constants of the rational approximation block
`timescale 1ns / 1ps

package bra_pkg;

  // tolerance is 1/EPS_INVERSE; EPS_INV_LOG2 is floor(log2(EPS_INVERSE))
  localparam int EPS_INV_BITS = 30;
  localparam int EPS_INV_LOG2 = 29;
  localparam logic [EPS_INV_BITS-1:0] EPS_INVERSE = 30'd1000000000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIFF,
    S_TOL,
    S_DEC,
    S_X_MUL_R,
    S_X_DIFF_R,
    S_X_SCALE_R,
    S_X_MUL_L,
    S_X_DIFF_L,
    S_X_SCALE_L,
    S_X_CMP,
    S_DONE
  } bra_state_t;

  typedef struct packed {
    logic mul_en;
    logic diff_en;
    logic tol_en;
  } bra_ctrl_t;

  typedef struct packed {
    logic in_tol;
    logic gt;
  } bra_stat_t;

endpackage

[hw/rtl/bra_if.sv]
// handshake channels: ratio input, fraction result and limit write
`timescale 1ns / 1ps

interface bra_ratio_if #(
  parameter int RATIO_BITS = 40
);
  logic                  valid;
  logic                  ready;
  logic [RATIO_BITS-1:0] ratio;
  modport source (output valid, output ratio, input ready);
  modport sink   (input valid, input ratio, output ready);
endinterface

interface bra_frac_if #(
  parameter int NUMERATOR_BITS   = 24,
  parameter int DENOMINATOR_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [NUMERATOR_BITS-1:0]   numerator;
  logic [DENOMINATOR_BITS-1:0] denominator;
  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface bra_cfg_if #(
  parameter int DENOMINATOR_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [DENOMINATOR_BITS-1:0] denominator_limit;
  modport source (output valid, output denominator_limit, input ready);
  modport sink   (input valid, input denominator_limit, output ready);
endinterface

[hw/rtl/bra_arith.sv]
// shared arithmetic unit: registered multiplier, distance/compare and tolerance scaling
`timescale 1ns / 1ps

module bra_arith import bra_pkg::*; #(
  parameter int FRACTION_BITS    = 32,
  parameter int INTEGER_BITS     = 8,
  parameter int DENOMINATOR_BITS = 16,
  localparam int QW  = DENOMINATOR_BITS + 1,
  localparam int NW  = INTEGER_BITS + DENOMINATOR_BITS + 2,
  localparam int DW  = FRACTION_BITS + INTEGER_BITS + DENOMINATOR_BITS + 2,
  localparam int PW  = DW + QW
) (
  input  logic          clk,
  input  bra_ctrl_t     ctrl,
  input  logic [DW-1:0] mul_a,
  input  logic [QW-1:0] mul_b,
  input  logic [NW-1:0] diff_num,
  input  logic [QW-1:0] cmp_q,
  output logic [PW-1:0] prod,
  output logic [DW-1:0] gap,
  output bra_stat_t     stat
);

  // a distance of 2^TB or more can never be within tolerance
  localparam int TB  = (QW + FRACTION_BITS > EPS_INV_LOG2) ?
                       QW + FRACTION_BITS - EPS_INV_LOG2 : 0;
  localparam int TW  = (TB > 0) ? TB : 1;
  localparam int TPW = TW + EPS_INV_BITS;
  localparam int QFW = QW + FRACTION_BITS;
  localparam int CW  = (TPW > QFW) ? TPW : QFW;

  logic [PW-1:0]  prod_r;
  logic [DW-1:0]  dist_r;
  logic           gt_r;
  logic           small_r;
  logic [TPW-1:0] tol_r;

  logic [PW-1:0]  num_ext;
  logic           gt;
  logic [PW-1:0]  diff;

  always_comb begin
    num_ext = PW'({diff_num, {FRACTION_BITS{1'b0}}});
    gt      = num_ext < prod_r;
    diff    = gt ? (prod_r - num_ext) : (num_ext - prod_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
    end
    if (ctrl.diff_en) begin
      dist_r  <= diff[DW-1:0];
      gt_r    <= gt;
      small_r <= (diff >> TB) == '0;
    end
    if (ctrl.tol_en) begin
      tol_r <= TPW'(dist_r[TW-1:0]) * TPW'(EPS_INVERSE);
    end
  end

  assign prod        = prod_r;
  assign gap         = dist_r;
  assign stat.gt     = gt_r;
  assign stat.in_tol = small_r &&
                       (CW'(tol_r) < CW'({cmp_q, {FRACTION_BITS{1'b0}}}));

endmodule

[hw/rtl/best_rational_approximation_top.sv]
// Best rational approximation: takes an unsigned fixed-point ratio (INTEGER_BITS.FRACTION_BITS)
// and returns numerator/denominator of a close fraction whose denominator stays at or under
// the denominator_limit register (reset value all ones; the user must see that it is written
// over the cfg channel only while idle, as the block does not enforce this). A Farey mediant
// search runs from 0/1 and 1/0, all comparisons cross-multiplied exactly; a mediant within
// 1e-9 of the ratio ends the search early. One item at a time: each mediant step runs through
// S_CHECK, S_MUL, S_DIFF, S_TOL and S_DEC on the one shared multiplier and compare unit, the
// number of steps is at most about denominator_limit plus the ratio's integer part, and an
// exhausted search ends with the final nearest-bound choice through the S_X_* states. The
// result sits in an output register, so the next item is taken while it waits.
`timescale 1ns / 1ps

module best_rational_approximation_top import bra_pkg::*; #(
  parameter int FRACTION_BITS    = 32,
  parameter int INTEGER_BITS     = 8,
  parameter int DENOMINATOR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bra_ratio_if.sink   in_if,
  bra_frac_if.source  out_if,
  bra_cfg_if.sink     cfg_if
);

  localparam int RW   = FRACTION_BITS + INTEGER_BITS;
  localparam int QW   = DENOMINATOR_BITS + 1;
  localparam int NW   = INTEGER_BITS + DENOMINATOR_BITS + 2;
  localparam int DW   = FRACTION_BITS + INTEGER_BITS + DENOMINATOR_BITS + 2;
  localparam int PW   = DW + QW;
  localparam int NUMW = INTEGER_BITS + DENOMINATOR_BITS;

  bra_state_t state_r, state_nxt;
  bra_ctrl_t  ctrl;
  bra_stat_t  stat;

  logic [DENOMINATOR_BITS-1:0] lim_r;
  logic [RW-1:0]               ratio_r;
  logic [NW-1:0]               a_r, c_r, pa_r, pc_r, p_r, res_num_r;
  logic [QW-1:0]               b_r, d_r, pb_r, pd_r, q_r, res_den_r;
  logic [PW-1:0]               hold_r;
  logic                        out_valid_r;
  logic [NUMW-1:0]             out_num_r;
  logic [DENOMINATOR_BITS-1:0] out_den_r;

  logic [DW-1:0] mul_a;
  logic [QW-1:0] mul_b;
  logic [NW-1:0] diff_num;
  logic [PW-1:0] prod;
  logic [DW-1:0] gap;
  logic [QW-1:0] lim_ext;
  logic          loop_go;
  logic          in_fire;
  logic          out_load;

  assign lim_ext  = QW'(lim_r);
  assign loop_go  = (b_r <= lim_ext) && (d_r <= lim_ext);
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  bra_arith #(
    .FRACTION_BITS    (FRACTION_BITS),
    .INTEGER_BITS     (INTEGER_BITS),
    .DENOMINATOR_BITS (DENOMINATOR_BITS)
  ) u_arith (
    .clk      (clk),
    .ctrl     (ctrl),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .diff_num (diff_num),
    .cmp_q    (q_r),
    .prod     (prod),
    .gap      (gap),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    mul_a     = '0;
    mul_b     = '0;
    diff_num  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (loop_go) begin
          state_nxt = S_MUL;
        end else if (pd_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_X_MUL_R;
        end
      end
      S_MUL: begin
        ctrl.mul_en = 1'b1;
        mul_a       = DW'(ratio_r);
        mul_b       = q_r;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        ctrl.diff_en = 1'b1;
        diff_num     = p_r;
        state_nxt    = S_TOL;
      end
      S_TOL: begin
        ctrl.tol_en = 1'b1;
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        state_nxt = stat.in_tol ? S_DONE : S_CHECK;
      end
      // exhausted: compare |r*pd - pc|*pb against |r*pb - pa|*pd
      S_X_MUL_R: begin
        ctrl.mul_en = 1'b1;
        mul_a       = DW'(ratio_r);
        mul_b       = pd_r;
        state_nxt   = S_X_DIFF_R;
      end
      S_X_DIFF_R: begin
        ctrl.diff_en = 1'b1;
        diff_num     = pc_r;
        state_nxt    = S_X_SCALE_R;
      end
      S_X_SCALE_R: begin
        ctrl.mul_en = 1'b1;
        mul_a       = gap;
        mul_b       = pb_r;
        state_nxt   = S_X_MUL_L;
      end
      S_X_MUL_L: begin
        ctrl.mul_en = 1'b1;
        mul_a       = DW'(ratio_r);
        mul_b       = pb_r;
        state_nxt   = S_X_DIFF_L;
      end
      S_X_DIFF_L: begin
        ctrl.diff_en = 1'b1;
        diff_num     = pa_r;
        state_nxt    = S_X_SCALE_L;
      end
      S_X_SCALE_L: begin
        ctrl.mul_en = 1'b1;
        mul_a       = gap;
        mul_b       = pd_r;
        state_nxt   = S_X_CMP;
      end
      S_X_CMP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // bounds, mediant and result registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ratio_r <= in_if.ratio;
          a_r     <= '0;
          b_r     <= QW'(1);
          c_r     <= NW'(1);
          d_r     <= '0;
          pa_r    <= '0;
          pb_r    <= QW'(1);
          pc_r    <= NW'(1);
          pd_r    <= '0;
        end
      end
      S_CHECK: begin
        if (loop_go) begin
          p_r <= a_r + c_r;
          q_r <= b_r + d_r;
        end else begin
          res_num_r <= pa_r;
          res_den_r <= pb_r;
        end
      end
      S_DEC: begin
        if (stat.in_tol) begin
          priority if (q_r <= lim_ext) begin
            res_num_r <= p_r;
            res_den_r <= q_r;
          end else if (d_r > b_r) begin
            res_num_r <= c_r;
            res_den_r <= d_r;
          end else begin
            res_num_r <= a_r;
            res_den_r <= b_r;
          end
        end else if (stat.gt) begin
          // ratio above the mediant: it becomes the left bound
          pa_r <= a_r;
          pb_r <= b_r;
          a_r  <= p_r;
          b_r  <= q_r;
        end else begin
          pc_r <= c_r;
          pd_r <= d_r;
          c_r  <= p_r;
          d_r  <= q_r;
        end
      end
      S_X_MUL_L: begin
        hold_r <= prod;
      end
      S_X_CMP: begin
        if (hold_r < prod) begin
          res_num_r <= pc_r;
          res_den_r <= pd_r;
        end else begin
          res_num_r <= pa_r;
          res_den_r <= pb_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        lim_r <= cfg_if.denominator_limit;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_num_r <= res_num_r[NUMW-1:0];
      out_den_r <= res_den_r[DENOMINATOR_BITS-1:0];
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = out_valid_r;
  assign out_if.numerator   = out_num_r;
  assign out_if.denominator = out_den_r;

endmodule

[hw/rtl/bra_checker.sv]
// port-level assertions for the rational approximation block, bound to the top level
`timescale 1ns / 1ps
`include "best_rational_approximation_top_defines.svh"

module bra_checker #(
  parameter int INTEGER_BITS     = 8,
  parameter int DENOMINATOR_BITS = 16
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [INTEGER_BITS+DENOMINATOR_BITS-1:0] out_numerator,
  input logic [DENOMINATOR_BITS-1:0]          out_denominator,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [DENOMINATOR_BITS-1:0]          cfg_limit
);

  logic [DENOMINATOR_BITS-1:0] lim_r;
  logic [1:0]                  pend_r;
  logic                        in_acc;
  logic                        out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // shadow of the limit register and count of items without a delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r  <= '1;
      pend_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lim_r <= cfg_limit;
      end
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  `BRA_ASSERT_IMP(a_den_in_range, out_valid && (lim_r != '0), (out_denominator != '0) && (out_denominator <= lim_r), "result denominator outside 1..limit")
  `BRA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_numerator) && $stable(out_denominator), "stalled result changed")
  `BRA_ASSERT_IMP(a_no_spurious, out_valid, pend_r != 2'd0, "result without an accepted item")
  `BRA_ASSERT_IMP(a_one_waiting, in_acc, pend_r < 2'd2, "item accepted with two items outstanding")

endmodule

bind best_rational_approximation_top bra_checker #(
  .INTEGER_BITS     (INTEGER_BITS),
  .DENOMINATOR_BITS (DENOMINATOR_BITS)
) u_bra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_numerator   (out_if.numerator),
  .out_denominator (out_if.denominator),
  .cfg_valid       (cfg_if.valid),
  .cfg_ready       (cfg_if.ready),
  .cfg_limit       (cfg_if.denominator_limit)
);
